// ===== hw/rtl/u16u8_pkg.sv =====
// Shared types, constants and the UTF-8 encode function of the UTF-16LE to UTF-8 transcoder.
// No dependencies.
`default_nettype none
package u16u8_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CAP_W   = 17;
  localparam int CP_W    = 21;
  localparam int UNIT_W  = 16;
  localparam int SURR_W  = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TERM     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

  localparam logic [UNIT_W-1:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [UNIT_W-1:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h10000;
  localparam logic [CP_W-1:0]   MAX_3BYTE    = 21'h0FFFF;
  localparam logic [CP_W-1:0]   MAX_2BYTE    = 21'h007FF;
  localparam logic [CP_W-1:0]   MAX_1BYTE    = 21'h0007F;

  // One queued item of work: a status result, or 1..4 bytes with an optional terminator.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [2:0]             nbytes;
    logic                   term;
    logic                   err;
    logic [KIND_W-1:0]      err_kind;
  } job_t;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [2:0]             len;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [CP_W-1:0] cp);
    enc_t e;
    e = '0;
    if (cp > MAX_3BYTE) begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len      = 3'd4;
    end else if (cp > MAX_2BYTE) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end else if (cp > MAX_1BYTE) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.len      = 3'd1;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/u16u8_ifs.sv =====
// Valid/ready channel interfaces of the transcoder: UTF-16LE input, UTF-8 output, config write.
// Depends on u16u8_pkg.
`default_nettype none
interface u16u8_in_if;
  logic                           valid;
  logic                           ready;
  logic [u16u8_pkg::BYTE_W-1:0]   in_byte;
  logic                           in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u16u8_out_if;
  logic                           valid;
  logic                           ready;
  logic [u16u8_pkg::BYTE_W-1:0]   out_byte;
  logic [u16u8_pkg::KIND_W-1:0]   out_kind;
  logic                           out_last;
  modport source (output valid, output out_byte, output out_kind, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input out_last, output ready);
endinterface

interface u16u8_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [u16u8_pkg::CAP_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/u16u8_queue.sv =====
// Small flop FIFO of job records between the front and back ends.
// Depends on u16u8_pkg.
`default_nettype none
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  u16u8_pkg::job_t        push_data,
  output logic                   full,
  input  wire                    pop,
  output u16u8_pkg::job_t        pop_data,
  output logic                   empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u16u8_pkg::job_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/u16u8_front.sv =====
// Front end: takes UTF-16LE bytes, pairs units, joins surrogates, checks room,
// and queues one job per item that gives results. Depends on u16u8_pkg.
`default_nettype none
module u16u8_front (
  input  wire                               clk,
  input  wire                               rst,
  u16u8_in_if.sink                          utf16,
  input  wire [u16u8_pkg::CAP_W-1:0]        capacity,
  input  wire                               queue_full,
  output logic                              push,
  output u16u8_pkg::job_t                   job
);
  // per-string state
  logic                            odd_byte_held, odd_byte_held_next;
  logic [u16u8_pkg::BYTE_W-1:0]    held_low_byte, held_low_byte_next;
  logic                            high_surrogate_pending, high_surrogate_pending_next;
  logic [u16u8_pkg::SURR_W-1:0]    high_surrogate_bits, high_surrogate_bits_next;
  logic [u16u8_pkg::CAP_W-1:0]     bytes_written, bytes_written_next;
  logic                            dropping_after_error, dropping_after_error_next;

  logic                            acc;
  logic [u16u8_pkg::UNIT_W-1:0]    unit;
  logic                            is_high;
  logic                            is_low;
  logic [u16u8_pkg::CP_W-1:0]      cp;
  u16u8_pkg::enc_t                 enc;
  logic [u16u8_pkg::CAP_W:0]       room_need;
  logic                            no_room;
  logic                            have_cp;
  logic                            bad;

  assign utf16.ready = !queue_full;
  assign acc         = utf16.valid && utf16.ready;

  assign unit    = {utf16.in_byte, held_low_byte};
  assign is_high = (unit >= u16u8_pkg::HIGH_SURR_LO) && (unit < u16u8_pkg::LOW_SURR_LO);
  assign is_low  = (unit >= u16u8_pkg::LOW_SURR_LO) && (unit <= u16u8_pkg::LOW_SURR_HI);
  assign cp      = high_surrogate_pending
                 ? u16u8_pkg::SUPP_BASE + u16u8_pkg::CP_W'({high_surrogate_bits, unit[9:0]})
                 : u16u8_pkg::CP_W'(unit);
  assign enc       = u16u8_pkg::utf8_encode(cp);
  // bytes so far + this code point + terminator
  assign room_need = {1'b0, bytes_written} + (u16u8_pkg::CAP_W+1)'(enc.len)
                   + (u16u8_pkg::CAP_W+1)'(1);
  assign no_room   = room_need > {1'b0, capacity};

  always_comb begin
    odd_byte_held_next          = odd_byte_held;
    held_low_byte_next          = held_low_byte;
    high_surrogate_pending_next = high_surrogate_pending;
    high_surrogate_bits_next    = high_surrogate_bits;
    bytes_written_next          = bytes_written;
    dropping_after_error_next   = dropping_after_error;
    push    = 1'b0;
    job     = '0;
    have_cp = 1'b0;
    bad     = 1'b0;

    if (acc) begin
      if (dropping_after_error) begin
        if (utf16.in_last) begin
          dropping_after_error_next   = 1'b0;
          odd_byte_held_next          = 1'b0;
          held_low_byte_next          = '0;
          high_surrogate_pending_next = 1'b0;
          high_surrogate_bits_next    = '0;
          bytes_written_next          = '0;
        end
      end else if (!odd_byte_held) begin
        if (utf16.in_last) begin
          // odd byte count
          bad = 1'b1;
        end else begin
          odd_byte_held_next = 1'b1;
          held_low_byte_next = utf16.in_byte;
        end
      end else begin
        odd_byte_held_next = 1'b0;
        if (high_surrogate_pending) begin
          if (is_low) begin
            have_cp                     = 1'b1;
            high_surrogate_pending_next = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end else if (is_high) begin
          if (utf16.in_last) begin
            bad = 1'b1;
          end else begin
            high_surrogate_pending_next = 1'b1;
            high_surrogate_bits_next    = unit[9:0];
          end
        end else if (is_low) begin
          bad = 1'b1;
        end else begin
          have_cp = 1'b1;
        end
      end

      if (bad || (have_cp && no_room)) begin
        push         = 1'b1;
        job.err      = 1'b1;
        job.err_kind = bad ? u16u8_pkg::KIND_BAD : u16u8_pkg::KIND_OVERFLOW;
        odd_byte_held_next          = 1'b0;
        high_surrogate_pending_next = 1'b0;
        dropping_after_error_next   = !utf16.in_last;
      end else if (have_cp) begin
        // room for bytes plus terminator was checked, so the terminator always fits
        push               = 1'b1;
        job.bytes          = enc.bytes;
        job.nbytes         = enc.len;
        job.term           = utf16.in_last;
        bytes_written_next = room_need[u16u8_pkg::CAP_W-1:0] - 1'b1;
      end

      if (utf16.in_last && !dropping_after_error) begin
        odd_byte_held_next          = 1'b0;
        held_low_byte_next          = '0;
        high_surrogate_pending_next = 1'b0;
        high_surrogate_bits_next    = '0;
        bytes_written_next          = '0;
        dropping_after_error_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_byte_held          <= 1'b0;
      held_low_byte          <= '0;
      high_surrogate_pending <= 1'b0;
      high_surrogate_bits    <= '0;
      bytes_written          <= '0;
      dropping_after_error   <= 1'b0;
    end else begin
      odd_byte_held          <= odd_byte_held_next;
      held_low_byte          <= held_low_byte_next;
      high_surrogate_pending <= high_surrogate_pending_next;
      high_surrogate_bits    <= high_surrogate_bits_next;
      bytes_written          <= bytes_written_next;
      dropping_after_error   <= dropping_after_error_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
      (acc && dropping_after_error) |-> !push)
    else $error("job queued while dropping");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/u16u8_back.sv =====
// Back end: unrolls queued jobs into result items, one per cycle while a job is queued and the output is ready.
// Depends on u16u8_pkg.
`default_nettype none
module u16u8_back (
  input  wire                  clk,
  input  wire                  rst,
  input  u16u8_pkg::job_t      head,
  input  wire                  queue_empty,
  output logic                 pop,
  u16u8_out_if.source          utf8
);
  u16u8_pkg::job_t cur;
  logic            cur_valid;
  logic [2:0]      pos;

  logic at_term;
  logic is_last;
  logic acc;
  logic done;

  assign at_term = !cur.err && (pos == cur.nbytes);
  assign is_last = cur.err || at_term || ((pos == cur.nbytes - 3'd1) && !cur.term);

  assign utf8.valid    = cur_valid;
  assign utf8.out_last = is_last;
  assign utf8.out_byte = (cur.err || at_term) ? '0 : cur.bytes[pos[1:0]];
  assign utf8.out_kind = cur.err ? cur.err_kind
                       : at_term ? u16u8_pkg::KIND_TERM : u16u8_pkg::KIND_BYTE;

  assign acc  = utf8.valid && utf8.ready;
  assign done = acc && is_last;
  assign pop  = (!cur_valid || done) && !queue_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        pos       <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (acc) begin
        pos <= pos + 3'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
      (utf8.valid && utf8.out_kind != u16u8_pkg::KIND_BYTE) |-> utf8.out_last)
    else $error("status or terminator item without last flag");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
      cur_valid |-> (pos <= cur.nbytes))
    else $error("result position past end of job");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/utf16le_to_utf8_transcoder_unit.sv =====
// UTF-16LE to UTF-8 transcoder, top level: front end, job queue, back end, capacity register.
// Depends on u16u8_pkg, u16u8_ifs, u16u8_front, u16u8_queue, u16u8_back.
//
// Takes a UTF-16LE string one byte per item (in_last on the final byte) and gives
// UTF-8 bytes (kind 0), then a zero terminator (kind 1) after the last item. Bad
// surrogates or an odd byte count give one kind-2 item, lack of room under
// output_capacity gives one kind-3 item; after either the rest of the string is
// dropped silently up to its flagged byte. out_last marks the last result of each
// input item. Timing: the front end takes one input byte per cycle while the job
// queue has space; the back end sends one result per cycle while a job is queued
// and the output is ready, and its single output stage sets the sustained rate.
// With the queue empty, a completing input byte reaches its first result through
// the queue write, then the job load into the output stage. The capacity register
// is taken on any cycle (cfg.ready is always high) and should be written only while
// idle.
`default_nettype none
module utf16le_to_utf8_transcoder_unit #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire          clk,
  input  wire          rst,
  u16u8_in_if.sink     utf16,
  u16u8_out_if.source  utf8,
  u16u8_cfg_if.sink    cfg
);
  logic [u16u8_pkg::CAP_W-1:0] capacity;

  u16u8_pkg::job_t push_job;
  u16u8_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // output_capacity register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= u16u8_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // classify input, track per-string state
  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .utf16      (utf16),
    .capacity   (capacity),
    .queue_full (q_full),
    .push       (push),
    .job        (push_job)
  );

  // decouples input acceptance from result serialization
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_job),
    .empty     (q_empty)
  );

  // one result item per cycle while the output is ready
  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .queue_empty (q_empty),
    .pop         (pop),
    .utf8        (utf8)
  );

endmodule
`default_nettype wire

// ===== sim/utf8_result_checker.sv =====
// Result checker for the UTF-16LE to UTF-8 transcoder: predicts the output items from the input
// and config traffic it sees and compares them with the accepted output items.
// Depends on u16u8_pkg and the channel interfaces in u16u8_ifs.
`timescale 1ns / 1ps
module utf8_result_checker
  import u16u8_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  u16u8_in_if   utf16,
  u16u8_out_if  utf8,
  u16u8_cfg_if  cfg,
  output int    mismatches,
  output int    pending_results,
  output int    sent_bytes
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              last;
  } utf8_result_t;

  utf8_result_t utf8_expected[$];
  int           error_count;

  // Mirror of the block's state
  logic [CAP_W-1:0]  capacity;
  logic              odd_held;
  logic [BYTE_W-1:0] low_byte;
  logic              high_pending;
  logic [SURR_W-1:0] high_bits;
  int                written;
  logic              dropping;
  int                sent_count;

  assign mismatches = error_count;

  function automatic void end_of_string();
    odd_held     = 1'b0;
    low_byte     = '0;
    high_pending = 1'b0;
    high_bits    = '0;
    written      = 0;
    dropping     = 1'b0;
  endfunction

  // One status item; the rest of the string is dropped unless it just ended.
  function automatic void status_item(input logic [KIND_W-1:0] kind, input logic final_byte);
    utf8_result_t r;
    r.data = '0;
    r.kind = kind;
    r.last = 1'b1;
    utf8_expected.push_back(r);
    if (final_byte) begin
      end_of_string();
    end else begin
      dropping     = 1'b1;
      odd_held     = 1'b0;
      high_pending = 1'b0;
    end
  endfunction

  function automatic void transcode_byte(input logic [BYTE_W-1:0] b, input logic final_byte);
    logic [UNIT_W-1:0] unit;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] seq [4];
    int                len;
    utf8_result_t      r;
    if (dropping) begin
      if (final_byte) end_of_string();
      return;
    end
    if (!odd_held) begin
      if (final_byte) begin
        status_item(KIND_BAD, 1'b1);
        return;
      end
      odd_held = 1'b1;
      low_byte = b;
      return;
    end
    odd_held = 1'b0;
    unit = {b, low_byte};
    if (high_pending) begin
      if (unit < LOW_SURR_LO || unit > LOW_SURR_HI) begin
        status_item(KIND_BAD, final_byte);
        return;
      end
      high_pending = 1'b0;
      cp = SUPP_BASE + {1'b0, high_bits, unit[SURR_W-1:0]};
    end else if (unit >= HIGH_SURR_LO && unit < LOW_SURR_LO) begin
      if (final_byte) begin
        status_item(KIND_BAD, 1'b1);
        return;
      end
      high_pending = 1'b1;
      high_bits    = unit[SURR_W-1:0];
      return;
    end else if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI) begin
      status_item(KIND_BAD, final_byte);
      return;
    end else begin
      cp = {5'b0, unit};
    end

    if (cp > MAX_3BYTE) begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      len = 4;
    end else if (cp > MAX_2BYTE) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      len = 3;
    end else if (cp > MAX_1BYTE) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      len = 2;
    end else begin
      seq[0] = {1'b0, cp[6:0]};
      len = 1;
    end

    // room for the code point and a terminator
    if (written + len + 1 > int'(capacity)) begin
      status_item(KIND_OVERFLOW, final_byte);
      return;
    end
    for (int i = 0; i < len; i++) begin
      r.data = seq[i];
      r.kind = KIND_BYTE;
      r.last = (i == len - 1) && !final_byte;
      utf8_expected.push_back(r);
    end
    written += len;
    if (final_byte) begin
      r.data = '0;
      r.kind = KIND_TERM;
      r.last = 1'b1;
      utf8_expected.push_back(r);
      end_of_string();
    end
  endfunction

  always @(posedge clk) begin
    utf8_result_t want;
    if (rst) begin
      capacity = CAP_RESET;
      end_of_string();
      utf8_expected.delete();
      sent_count = 0;
    end else begin
      if (utf16.valid && utf16.ready) begin
        sent_count++;
        transcode_byte(utf16.in_byte, utf16.in_last);
      end
      if (cfg.valid && cfg.ready) capacity = cfg.data;
      if (utf8.valid && utf8.ready) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected item: out_byte 0x%02h out_kind %0d out_last %0d",
                 utf8.out_byte, utf8.out_kind, utf8.out_last);
          error_count++;
        end else begin
          want = utf8_expected.pop_front();
          if (utf8.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, utf8.out_byte);
            error_count++;
          end
          if (utf8.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, utf8.out_kind);
            error_count++;
          end
          if (utf8.out_last !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, utf8.out_last);
            error_count++;
          end
        end
      end
    end
    pending_results <= utf8_expected.size();
    sent_bytes      <= sent_count;
  end

endmodule

// ===== sim/utf16le_to_utf8_transcoder_unit_tb.sv =====
// Testbench top for utf16le_to_utf8_transcoder_unit: drives UTF-16LE strings and capacity writes,
// stalls the UTF-8 side, and gives the verdict from utf8_result_checker.
// Depends on u16u8_pkg, u16u8_ifs, the transcoder RTL and utf8_result_checker.
`timescale 1ns / 1ps
module utf16le_to_utf8_transcoder_unit_tb;
  import u16u8_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 8;       // queue write, job load and a short queue
  localparam int RANDOM_BYTES  = 400;     // input bytes spread over the capacity phases

  logic clk;
  logic rst;
  int   cycle_count;
  int   mismatches;
  int   pending_results;
  int   sent_bytes;
  int   burst_left;

  logic [BYTE_W-1:0] utf16_bytes[$];  // string being assembled, low byte of each unit first

  u16u8_in_if  utf16 ();
  u16u8_out_if utf8 ();
  u16u8_cfg_if cfg ();

  utf16le_to_utf8_transcoder_unit uut (
    .clk  (clk),
    .rst  (rst),
    .utf16(utf16),
    .utf8 (utf8),
    .cfg  (cfg)
  );

  utf8_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .utf16          (utf16),
    .utf8           (utf8),
    .cfg            (cfg),
    .mismatches     (mismatches),
    .pending_results(pending_results),
    .sent_bytes     (sent_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // UTF-8 side: each stretch picks a stall style, from always ready to mostly stalled.
  initial begin : sink_stall
    int mode;
    int left;
    mode = 0;
    left = 0;
    utf8.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: utf8.ready <= 1'b1;
        1: utf8.ready <= ($urandom_range(0, 3) != 0);
        2: utf8.ready <= ($urandom_range(0, 3) == 0);
        default: utf8.ready <= (left % 6 < 2);  // regular stall pattern
      endcase
    end
  end

  function automatic void add_unit(input logic [UNIT_W-1:0] u);
    utf16_bytes.push_back(u[7:0]);
    utf16_bytes.push_back(u[15:8]);
  endfunction

  // Send one item. The sender works in bursts; between bursts valid may drop for a
  // random gap. Valid stays high from item to item within a burst.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic final_byte);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        utf16.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    utf16.valid   <= 1'b1;
    utf16.in_byte <= b;
    utf16.in_last <= final_byte;
    @(posedge clk);
    while (!utf16.ready) @(posedge clk);
    burst_left--;
  endtask

  // Send the assembled string, flag on its final byte.
  task automatic send_string();
    for (int i = 0; i < utf16_bytes.size(); i++)
      send_byte(utf16_bytes[i], i == utf16_bytes.size() - 1);
    utf16_bytes.delete();
  endtask

  // Drop valid, wait for every predicted item to arrive, then let the pipe drain.
  task automatic wait_idle();
    utf16.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Mostly well-formed text of every UTF-8 length with random content; the rest
  // is noise, stray surrogates and the odd trailing byte.
  task automatic random_string();
    int                units;
    int                pick;
    logic [SURR_W-1:0] hi;
    logic [SURR_W-1:0] lo;
    units = $urandom_range(0, 9) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 6);
    for (int i = 0; i < units; i++) begin
      pick = $urandom_range(0, 99);
      hi   = SURR_W'($urandom_range(0, 1023));
      lo   = SURR_W'($urandom_range(0, 1023));
      if (pick < 30) begin
        add_unit(UNIT_W'($urandom_range(16'h0000, 16'h007F)));
      end else if (pick < 45) begin
        add_unit(UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 65) begin
        if ($urandom_range(0, 1)) add_unit(UNIT_W'($urandom_range(16'h0800, 16'hD7FF)));
        else                      add_unit(UNIT_W'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (pick < 85) begin
        add_unit(HIGH_SURR_LO | hi);
        add_unit(LOW_SURR_LO | lo);
      end else if (pick < 90) begin
        add_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 94) begin
        add_unit(LOW_SURR_LO | lo);        // lone low surrogate
      end else if (pick < 97) begin
        add_unit(HIGH_SURR_LO | hi);       // high surrogate, partner left to chance
      end else begin
        add_unit(LOW_SURR_LO | lo);        // pair in the wrong order
        add_unit(HIGH_SURR_LO | hi);
      end
    end
    if ($urandom_range(0, 19) == 0) utf16_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    send_string();
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] capacity_plan[$];
    int               phase_target;
    rst           <= 1'b1;
    utf16.valid   <= 1'b0;
    utf16.in_byte <= '0;
    utf16.in_last <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed strings at the reset capacity.
    // both ends of the 1-, 2- and 3-byte UTF-8 lengths; also carries in_byte 0x00 and 0xFF
    add_unit(16'h0000);
    add_unit(16'h007F);
    add_unit(16'h0080);
    add_unit(16'h07FF);
    add_unit(16'h0800);
    add_unit(16'hFFFF);
    send_string();
    // lowest and highest supplementary code points
    add_unit(16'hD800);
    add_unit(16'hDC00);
    add_unit(16'hDBFF);
    add_unit(16'hDFFF);
    send_string();
    // lone low surrogate mid-string: status item, then the tail is dropped
    add_unit(16'hDC00);
    add_unit(16'h0041);
    send_string();
    // high surrogate followed by an ordinary unit
    add_unit(16'hD800);
    add_unit(16'h0041);
    send_string();
    // high surrogate as the final unit
    add_unit(16'hDBFF);
    send_string();
    // odd byte count
    add_unit(16'h0041);
    utf16_bytes.push_back(8'h42);
    send_string();

    // Random phases over a range of capacities, field and range extremes included.
    capacity_plan = '{17'd65536, 17'd0, 17'd1, 17'd3, 17'd7, 17'h1FFFF,
                      CAP_W'($urandom_range(2, 30)), 17'd65536};
    foreach (capacity_plan[p]) begin
      write_capacity(capacity_plan[p]);
      phase_target = sent_bytes + RANDOM_BYTES / capacity_plan.size();
      while (sent_bytes < phase_target) random_string();
    end

    wait_idle();
    if (mismatches == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
